// ===== sv/esc_pkg.sv =====
// Shared types and constants for the elevator scan controller.
package esc_pkg;

  localparam int unsigned FLOORS = 8;
  localparam int unsigned FLOOR_W = 3;

  localparam logic [7:0] DOOR_TICKS_RST = 8'd10;
  localparam logic [7:0] TRAVEL_TICKS_RST = 8'd5;

  // Register index as decoded from paddr[2].
  localparam logic REG_DOOR_TICKS = 1'b0;
  localparam logic REG_TRAVEL_TICKS = 1'b1;

  typedef enum logic {
    OP_PRESS = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_DOOR = 2'd2
  } mode_e;

  typedef struct packed {
    logic               operation;
    logic [FLOOR_W-1:0] floor;
  } in_word_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] car_floor;
    logic [FLOOR_W-1:0] target_floor;
    logic               heading;
    logic [1:0]         mode;
    logic [FLOORS-1:0]  pending_mask;
    logic               served;
    logic [31:0]        wait_ticks;
  } out_word_t;

endpackage

// ===== sv/elevator_scan_controller_top.sv =====
// Single-car elevator controller with SCAN policy, one word per cycle while the result is not stalled.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------
//   in      | input     | in_valid_i, in_stall_o   | in_word_i  (press or tick)
//   out     | output    | out_valid_o, out_stall_i | out_word_o (car state)
//   cfg     | input     | psel/penable/pwrite      | paddr, pwdata, prdata
//
// An input word is registered, then the whole state update runs combinationally
// into the state registers and the result register: the result word passes through
// the input register and then the result register, one word per cycle while unstalled.
// Reset clears all car state, press stamps and valid flags, and loads the configuration defaults.
// in_stall_o rises only while both the input and the result register are full
// and the result is stalled; the stalled word then waits in the input register.
module elevator_scan_controller_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  esc_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output esc_pkg::out_word_t   out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned FW = esc_pkg::FLOORS;
  localparam int unsigned PW = esc_pkg::FLOOR_W;

  // Configuration registers.
  logic [7:0] door_ticks_q, travel_ticks_q;

  // Pipeline registers.
  logic               in_valid_q;
  esc_pkg::in_word_t  in_word_q;
  logic               out_valid_q;
  esc_pkg::out_word_t out_word_q, out_word_d;

  // Car state.
  esc_pkg::mode_e mode_q, mode_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [PW-1:0]  dest_q, dest_d;
  logic           down_q, down_d;
  logic [7:0]     phase_q, phase_d;
  logic [FW-1:0]  req_q, req_d;
  logic [FW-1:0]  snap_q, snap_d;
  logic [31:0]    stamp_q [FW];
  logic [31:0]    clock_q, clock_d;

  logic           out_load;
  logic           work;
  logic           stamp_we;
  logic [PW-1:0]  stamp_waddr;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      esc_pkg::REG_DOOR_TICKS:   prdata = {24'd0, door_ticks_q};
      esc_pkg::REG_TRAVEL_TICKS: prdata = {24'd0, travel_ticks_q};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_ticks_q   <= esc_pkg::DOOR_TICKS_RST;
      travel_ticks_q <= esc_pkg::TRAVEL_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        esc_pkg::REG_DOOR_TICKS:   door_ticks_q <= pwdata[7:0];
        esc_pkg::REG_TRAVEL_TICKS: travel_ticks_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register loads when empty or drained this cycle.
  assign out_load    = !out_valid_q || !out_stall_i;
  assign work        = in_valid_q && out_load;
  assign in_stall_o  = in_valid_q && !out_load;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      out_word_q <= out_word_d;
    end
  end

  // Next-state logic for one word.
  always_comb begin
    logic [7:0]    ph;
    logic          run;
    logic [FW-1:0] here, below, above, up_req, dn_req;
    logic          go;
    logic          served;
    logic [31:0]   wait_v;

    mode_d      = mode_q;
    pos_d       = pos_q;
    dest_d      = dest_q;
    down_d      = down_q;
    phase_d     = phase_q;
    req_d       = req_q;
    snap_d      = snap_q;
    clock_d     = clock_q;
    stamp_we    = 1'b0;
    stamp_waddr = in_word_q.floor;
    ph          = phase_q + 8'd1;
    run         = 1'b0;
    go          = 1'b0;
    served      = 1'b0;
    wait_v      = '0;
    here        = '0;
    below       = '0;
    above       = '0;
    up_req      = '0;
    dn_req      = '0;

    if (in_word_q.operation == esc_pkg::OP_PRESS) begin
      req_d[in_word_q.floor] = 1'b1;
      stamp_we               = 1'b1;
    end else begin
      unique case (mode_q)
        esc_pkg::MODE_MOVE: begin
          phase_d = ph;
          if (ph >= travel_ticks_q) begin
            pos_d  = dest_q;
            mode_d = esc_pkg::MODE_IDLE;
            run    = 1'b1;
          end
        end
        esc_pkg::MODE_DOOR: begin
          phase_d = ph;
          if (ph >= door_ticks_q) begin
            snap_d = req_q;
            mode_d = esc_pkg::MODE_IDLE;
            run    = 1'b1;
          end
        end
        default: begin
          snap_d = req_q;
          run    = 1'b1;
        end
      endcase

      if (run) begin
        here   = FW'(1) << pos_d;
        below  = here - FW'(1);
        above  = ~(below | here);
        up_req = snap_d & above;
        dn_req = snap_d & below;
        if ((snap_d & here) != '0) begin
          mode_d  = esc_pkg::MODE_DOOR;
          phase_d = '0;
          req_d   = req_q & ~here;
          snap_d  = snap_d & ~here;
          served  = 1'b1;
          wait_v  = clock_q - stamp_q[pos_d];
        end else begin
          // Keep heading while requests lie ahead, else turn around.
          if (!down_q) begin
            if (up_req != '0) begin
              go = 1'b1;
            end else if (dn_req != '0) begin
              down_d = 1'b1;
              go     = 1'b1;
            end
          end else begin
            if (dn_req != '0) begin
              go = 1'b1;
            end else if (up_req != '0) begin
              down_d = 1'b0;
              go     = 1'b1;
            end
          end
          if (go) begin
            snap_d  = req_q;
            phase_d = '0;
            mode_d  = esc_pkg::MODE_MOVE;
            if (down_d) begin
              dest_d = (pos_d != '0) ? pos_d - PW'(1) : '0;
            end else begin
              dest_d = (pos_d != PW'(FW - 1)) ? pos_d + PW'(1) : pos_d;
            end
          end else begin
            mode_d = esc_pkg::MODE_IDLE;
          end
        end
      end
      clock_d = clock_q + 32'd1;
    end

    out_word_d.car_floor    = pos_d;
    out_word_d.target_floor = dest_d;
    out_word_d.heading      = down_d;
    out_word_d.mode         = mode_d;
    out_word_d.pending_mask = req_d;
    out_word_d.served       = served;
    out_word_d.wait_ticks   = wait_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= esc_pkg::MODE_IDLE;
      pos_q   <= '0;
      dest_q  <= '0;
      down_q  <= 1'b0;
      phase_q <= '0;
      req_q   <= '0;
      snap_q  <= '0;
      clock_q <= '0;
      for (int i = 0; i < FW; i++) begin
        stamp_q[i] <= '0;
      end
    end else if (work) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      dest_q  <= dest_d;
      down_q  <= down_d;
      phase_q <= phase_d;
      req_q   <= req_d;
      snap_q  <= snap_d;
      clock_q <= clock_d;
      if (stamp_we) begin
        stamp_q[stamp_waddr] <= clock_q;
      end
    end
  end

`ifndef ASSERT_OFF
  // A served word always shows the door open.
  a_served_door: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.served |-> out_word_o.mode == esc_pkg::MODE_DOOR)
    else $error("served word without door open");

  // A wait time is reported only with a served word.
  a_wait_served: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.served |-> out_word_o.wait_ticks == '0)
    else $error("wait time without service");

  // A move never covers more than one floor.
  a_one_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == esc_pkg::MODE_MOVE |->
      (dest_q == pos_q || dest_q == pos_q + PW'(1) || dest_q + PW'(1) == pos_q))
    else $error("move spans more than one floor");
`endif

endmodule
